@@ hdl/tidx_pkg.sv @@
// Shared types and constants for the sorted time index floor lookup.
// No dependencies; imported by tidx_engine and the top level.
package tidx_pkg;

   localparam int TIME_W      = 32;
   localparam int OFF_W       = 48;
   localparam int OP_W        = 2;
   localparam int ST_W        = 2;
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 48;

   localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_NOMATCH = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

   localparam logic [TIME_W-1:0] LATE_TOL_RESET = 32'd90;

   typedef struct packed {
      logic start;
      logic wr_en;
   } tidx_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } tidx_stat_type;

endpackage

@@ hdl/tidx_engine.sv @@
// Search engine: timestamp and offset memories plus the binary search sequencer.
// Depends on tidx_pkg.
module tidx_engine #(
   parameter int ENTRIES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tidx_pkg::tidx_ctrl_type            ctrl,
   input  logic [$clog2(ENTRIES)-1:0]         wr_addr,
   input  logic [tidx_pkg::TIME_W-1:0]        wr_time,
   input  logic [tidx_pkg::OFF_W-1:0]         wr_offset,
   input  logic [tidx_pkg::TIME_W-1:0]        key,
   input  logic [$clog2(ENTRIES)-1:0]         hi_init,
   output tidx_pkg::tidx_stat_type            stat,
   output logic [tidx_pkg::OFF_W-1:0]         found_offset
);
   import tidx_pkg::*;

   localparam int ADDR_W = $clog2(ENTRIES);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PROBE = 2'd1;
   localparam logic [1:0] S_OUT   = 2'd2;

   logic [TIME_W-1:0] time_mem [ENTRIES];
   logic [OFF_W-1:0]  off_mem  [ENTRIES];

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff;
   logic [TIME_W-1:0] key_ff, key_in;
   logic [TIME_W-1:0] time_rd_ff;
   logic [OFF_W-1:0]  off_rd_ff;
   logic [ADDR_W-1:0] t_addr, o_addr;

   // upper midpoint of [lo, hi]
   function automatic logic [ADDR_W-1:0] mid_of(input logic [ADDR_W-1:0] lo,
                                                input logic [ADDR_W-1:0] hi);
      logic [ADDR_W:0] span;
      span = {1'b0, hi} - {1'b0, lo} + {{ADDR_W{1'b0}}, 1'b1};
      return lo + span[ADDR_W:1];
   endfunction

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      key_in   = key_ff;
      t_addr   = mid_of(lo_ff, hi_ff);
      o_addr   = lo_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ctrl.start) begin
               lo_in    = '0;
               hi_in    = hi_init;
               key_in   = key;
               t_addr   = mid_of('0, hi_init);
               o_addr   = '0;
               state_in = (hi_init != '0) ? S_PROBE : S_OUT;
            end
         end
         S_PROBE: begin
            // shared compare: keep the floor side, drop the upper side
            if (time_rd_ff <= key_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - {{(ADDR_W-1){1'b0}}, 1'b1};
            end
            t_addr = mid_of(lo_in, hi_in);
            o_addr = lo_in;
            if (!(lo_in < hi_in)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      key_ff <= key_in;
      mid_ff <= t_addr;
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         time_mem[wr_addr] <= wr_time;
         off_mem[wr_addr]  <= wr_offset;
      end
      time_rd_ff <= time_mem[t_addr];
      off_rd_ff  <= off_mem[o_addr];
   end

   assign stat.busy    = (state_ff != S_IDLE);
   assign stat.done    = (state_ff == S_OUT);
   assign found_offset = off_rd_ff;

`ifndef ASSERT_OFF
   a_range_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (lo_ff < hi_ff))
      else $error("search range collapsed while probing");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !stat.done)
      else $error("done held for more than one cycle");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.wr_en |-> !stat.busy)
      else $error("memory write during search");
`endif

endmodule

@@ hdl/sorted_time_index_floor_lookup.sv @@
// Top level of the sorted time index floor lookup: handshakes, entry count,
// range checks, result register. Depends on tidx_pkg and tidx_engine.
// Flow: each result passes through the result register into the output register; a query
//   on two or more entries that passes the range checks first runs the binary search,
//   one memory probe per cycle through the engine's single compare unit.
// Throughput: one transaction at a time; the next request is taken once the
//   previous result has moved into the output register.
// Reset (synchronous, active high): table empty, late tolerance 90, no result pending.
module sorted_time_index_floor_lookup #(
   parameter int ENTRIES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // request data: entry_time [31:0], entry_offset [79:32]
   input  logic [tidx_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // request user: opcode [1:0]
   input  logic [tidx_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // response data: found_offset [47:0]
   output logic [tidx_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // response user: status [1:0]
   output logic [tidx_pkg::ST_W-1:0]           rsp_tuser,
   // late tolerance register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [31:0]                         csr_wdata
);
   import tidx_pkg::*;

   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   localparam logic [1:0] T_IDLE   = 2'd0;
   localparam logic [1:0] T_SEARCH = 2'd1;
   localparam logic [1:0] T_DONE   = 2'd2;

   // request fields
   logic [OP_W-1:0]   req_op;
   logic [TIME_W-1:0] req_time;
   logic [OFF_W-1:0]  req_off;
   assign req_op   = req_tuser;
   assign req_time = req_tdata[31:0];
   assign req_off  = req_tdata[79:32];

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] first_ff, first_in, last_ff, last_in;
   logic [TIME_W-1:0] tol_ff;
   logic [OFF_W-1:0]  res_off_ff, res_off_in;
   logic [ST_W-1:0]   res_st_ff, res_st_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]  rsp_off_ff, rsp_off_in;
   logic [ST_W-1:0]   rsp_st_ff, rsp_st_in;

   logic              req_fire;
   logic              out_free;
   logic [TIME_W-1:0] late_gap;
   logic [TIME_W-1:0] search_key;
   logic [CNT_W-1:0]  count_dec;

   tidx_ctrl_type     eng_ctrl;
   tidx_stat_type     eng_stat;
   logic [OFF_W-1:0]  eng_offset;

   assign req_tready = (state_ff == T_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // distance past the last entry; only meaningful when the time is past it
   assign late_gap   = req_time - last_ff;
   // clamp a late query onto the last entry
   assign search_key = (req_time > last_ff) ? last_ff : req_time;
   assign count_dec  = count_ff - CNT_ONE;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      res_off_in   = res_off_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_off_in   = rsp_off_ff;
      rsp_st_in    = rsp_st_ff;
      eng_ctrl     = '0;

      unique case (state_ff)
         T_IDLE: begin
            if (req_fire) begin
               res_off_in = '0;
               res_st_in  = ST_OK;
               state_in   = T_DONE;
               unique case (req_op)
                  OP_APPEND: begin
                     if (count_ff == CNT_FULL) begin
                        res_st_in = ST_FULL;
                     end else if (count_ff != '0 && req_time < last_ff) begin
                        // keep the table sorted: reject out-of-order appends
                        res_st_in = ST_NOMATCH;
                     end else begin
                        eng_ctrl.wr_en = 1'b1;
                        count_in       = count_ff + CNT_ONE;
                        last_in        = req_time;
                        if (count_ff == '0) begin
                           first_in = req_time;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_QUERY: begin
                     priority if (count_ff == '0) begin
                        res_st_in = ST_NOMATCH;
                     end else if (count_ff == CNT_ONE) begin
                        // single entry: report offset zero whatever the time
                        res_st_in = ST_OK;
                     end else if (req_time < first_ff) begin
                        res_st_in = ST_NOMATCH;
                     end else if (req_time > last_ff && late_gap > tol_ff) begin
                        res_st_in = ST_NOMATCH;
                     end else begin
                        eng_ctrl.start = 1'b1;
                        state_in       = T_SEARCH;
                     end
                  end
                  OP_NOP: begin
                     res_st_in = ST_OK;
                  end
                  default: begin
                     res_st_in = ST_OK;
                  end
               endcase
            end
         end
         T_SEARCH: begin
            if (eng_stat.done) begin
               res_off_in = eng_offset;
               res_st_in  = ST_OK;
               state_in   = T_DONE;
            end
         end
         T_DONE: begin
            // hold the result until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = res_off_ff;
               rsp_st_in    = res_st_ff;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tol_ff       <= LATE_TOL_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      first_ff   <= first_in;
      last_ff    <= last_in;
      res_off_ff <= res_off_in;
      res_st_ff  <= res_st_in;
      rsp_off_ff <= rsp_off_in;
      rsp_st_ff  <= rsp_st_in;
   end

   tidx_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (eng_ctrl),
      .wr_addr      (count_ff[ADDR_W-1:0]),
      .wr_time      (req_time),
      .wr_offset    (req_off),
      .key          (search_key),
      .hi_init      (count_dec[ADDR_W-1:0]),
      .stat         (eng_stat),
      .found_offset (eng_offset)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_off_ff;
   assign rsp_tuser  = rsp_st_ff;

`ifndef ASSERT_OFF
   a_done_in_search: assert property (@(posedge clock) disable iff (reset)
      eng_stat.done |-> (state_ff == T_SEARCH))
      else $error("engine finished outside a search");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count beyond table depth");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_CLEAR) |=> (count_ff == '0))
      else $error("clear did not empty the table");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_st_ff == ST_OK || rsp_st_ff == ST_NOMATCH
                        || rsp_st_ff == ST_FULL))
      else $error("undefined status code on response");
`endif

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for sorted_time_index_floor_lookup.
// Needs hdl/tidx_pkg.sv and the RTL. It predicts every response, applies random
// stalls on both streams, and reprograms the late tolerance between phases.
`timescale 1ns / 100ps

module tb_top;
   import tidx_pkg::*;

   localparam int TABLE_DEPTH   = 1024;
   localparam int SETTLE_CYCLES = 32;       // idle wait after draining; longer than the longest query search
   localparam int IDLE_LIMIT    = 20000;    // bound on any wait for responses to drain
   localparam int RANDOM_ITEMS  = 120;

   // one response as it appears on the response stream, expected or observed
   typedef struct packed {
      logic [OFF_W-1:0] found_offset;
      logic [ST_W-1:0]  status;
   } lookup_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [ST_W-1:0]        rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [31:0]            csr_wdata  = '0;

   // shadow copy of the index and the tolerance register
   logic [TIME_W-1:0] idx_time [TABLE_DEPTH];
   logic [OFF_W-1:0]  idx_off  [TABLE_DEPTH];
   int                idx_count = 0;
   logic [TIME_W-1:0] tol_model = LATE_TOL_RESET;

   lookup_result_type pending_results [$];

   bit                steady_mode = 1'b0;   // when set, neither side inserts idle cycles
   int                err_count    = 0;
   int                n_items      = 0;     // accepted requests other than no-ops
   int                n_nop        = 0;
   int                n_queries    = 0;
   int                n_matched    = 0;
   int                n_full       = 0;
   int                n_checked    = 0;
   int                n_tol_writes = 0;

   sorted_time_index_floor_lookup #(
      .ENTRIES (TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Watchdog: several times the slowest legal run (about 1300 transactions,
   // each with a long sender gap, a long receiver stall and a full search).
   initial begin
      #15_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Apply one request to the shadow index and return the response it must give.
   function automatic lookup_result_type predict_lookup(input logic [OP_W-1:0]   op,
                                                        input logic [TIME_W-1:0] t,
                                                        input logic [OFF_W-1:0]  off);
      lookup_result_type res;
      logic [TIME_W-1:0] newest;
      logic [TIME_W-1:0] probe;
      int                i;
      res.found_offset = '0;
      res.status       = ST_OK;
      case (op)
         OP_APPEND: begin
            if (idx_count >= TABLE_DEPTH) begin
               res.status = ST_FULL;
            end else if (idx_count > 0 && t < idx_time[idx_count-1]) begin
               // keep the table sorted: a late-arriving timestamp is refused
               res.status = ST_NOMATCH;
            end else begin
               idx_time[idx_count] = t;
               idx_off[idx_count]  = off;
               idx_count++;
            end
         end
         OP_CLEAR: begin
            idx_count = 0;
         end
         OP_QUERY: begin
            if (idx_count == 0) begin
               res.status = ST_NOMATCH;
            end else if (idx_count > 1) begin
               // a single entry always answers offset zero, so only search here
               newest = idx_time[idx_count-1];
               if (t < idx_time[0]) begin
                  res.status = ST_NOMATCH;
               end else if (t > newest && (t - newest) > tol_model) begin
                  res.status = ST_NOMATCH;
               end else begin
                  // clamp late queries to the newest entry, then walk down to the
                  // floor; scanning from the top picks the latest of equal stamps
                  probe = (t > newest) ? newest : t;
                  i = idx_count - 1;
                  while (i > 0 && idx_time[i] > probe) i--;
                  res.found_offset = idx_off[i];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Random helpers
   // ------------------------------------------------------------------

   // Idle length for either stream: mostly none or short, sometimes long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady_mode || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // Next timestamp of a sorted run: equal stamps, small steps and the odd jump.
   function automatic logic [31:0] next_time(input logic [31:0] prev);
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 4) return prev;
      if (roll < 15) return sat_add(prev, $urandom_range(1, 16));
      if (roll < 19) return sat_add(prev, $urandom_range(17, 5000));
      return sat_add(prev, $urandom_range(5001, 1000000));
   endfunction

   function automatic logic [31:0] pick_base_time();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 1000);
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 20000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [47:0] rand_offset();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return raw[47:0];
      endcase
   endfunction

   function automatic logic [31:0] pick_tolerance();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return 32'hFFFF_FFFF;
         3:       return LATE_TOL_RESET;
         4:       return $urandom_range(0, 5000);
         default: return $urandom;
      endcase
   endfunction

   // Query time aimed at the interesting spots of the current table: exact hits,
   // just off an entry, just before the first, around the tolerance edge.
   function automatic logic [31:0] pick_query_time();
      logic [63:0] first;
      logic [63:0] newest;
      logic [63:0] pick;
      logic [63:0] stamp;
      int          i;
      if (idx_count == 0) return $urandom;
      first  = idx_time[0];
      newest = idx_time[idx_count-1];
      i      = $urandom_range(0, idx_count - 1);
      stamp  = idx_time[i];
      case ($urandom_range(0, 8))
         0:       pick = stamp;
         1:       pick = stamp + 1;
         2:       pick = (first == 0) ? 0 : first - 1;
         3:       pick = newest + tol_model;
         4:       pick = newest + tol_model + 1;
         5:       pick = first + ((newest - first) * $urandom_range(0, 1000)) / 1000;
         6:       pick = $urandom;
         7:       pick = newest + $urandom_range(0, 200);
         default: pick = (stamp == 0) ? 0 : stamp - 1;
      endcase
      return (pick > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pick[31:0];
   endfunction

   // ------------------------------------------------------------------
   // Stream drivers
   // ------------------------------------------------------------------

   // Send one request; call at a rising edge. With a zero gap, valid is left high
   // so the next call can follow back to back.
   task automatic send_item(input logic [OP_W-1:0]   op,
                            input logic [TIME_W-1:0] t,
                            input logic [OFF_W-1:0]  off);
      lookup_result_type res;
      int                gap;
      req_tdata  <= {off, t};
      req_tuser  <= op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      res = predict_lookup(op, t, off);
      pending_results.push_back(res);
      if (op == OP_NOP) n_nop++;
      else n_items++;
      if (op == OP_QUERY) begin
         n_queries++;
         if (res.status == ST_OK) n_matched++;
      end
      if (res.status == ST_FULL) n_full++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending, drain every outstanding response, then let the block settle.
   task automatic wait_idle();
      int guard;
      req_tvalid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < IDLE_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (pending_results.size() != 0) begin
         err_count += pending_results.size();
         $display("ERROR: %0d responses never arrived", pending_results.size());
         pending_results.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Program the late tolerance; only called with the block idle.
   task automatic write_late_tolerance(input logic [31:0] value);
      csr_wdata <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tol_model = value;
      n_tol_writes++;
   endtask

   // Response backpressure: runs of ready, broken by stalls of random length.
   initial begin : rsp_backpressure
      int run;
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         run = pick_gap();
         if (run > 0) begin
            rsp_tready <= 1'b0;
            repeat (run) @(posedge clock);
         end
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin : check_responses
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("ERROR @%0t: unexpected response offset=%h status=%0d", $realtime,
                        rsp_tdata, rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (rsp_tdata !== want.found_offset || rsp_tuser !== want.status) begin
               err_count++;
               if (err_count <= 10)
                  $display({"ERROR @%0t: response %0d expected offset=%h status=%0d,",
                            " got offset=%h status=%0d"},
                           $realtime, n_checked, want.found_offset, want.status,
                           rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Empty table, clear and no-op on it, then a single entry that answers
   // offset zero whatever the query time.
   task automatic test_empty_and_single();
      send_item(OP_QUERY,  32'd0,         48'd0);
      send_item(OP_QUERY,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_item(OP_CLEAR,  32'd0,         48'd0);
      send_item(OP_NOP,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_item(OP_APPEND, 32'd1000,      48'h1234_5678_9ABC);
      send_item(OP_QUERY,  32'd0,         48'd0);
      send_item(OP_QUERY,  32'd1000,      48'd0);
      send_item(OP_QUERY,  32'hFFFF_FFFF, 48'd0);
   endtask

   // Floor search at reset tolerance: equal stamps, refused out-of-order append,
   // before the first entry, the tolerance edge, and both ends of the time range.
   task automatic test_floor_directed();
      send_item(OP_CLEAR,  32'd0,   48'd0);
      send_item(OP_APPEND, 32'd10,  48'd0);
      send_item(OP_APPEND, 32'd10,  48'hFFFF_FFFF_FFFF);
      send_item(OP_APPEND, 32'd20,  48'hAAAA_AAAA_AAAA);
      send_item(OP_APPEND, 32'd5,   48'h5555_5555_5555);
      send_item(OP_QUERY,  32'd9,   48'd0);
      send_item(OP_QUERY,  32'd10,  48'd0);
      send_item(OP_QUERY,  32'd15,  48'd0);
      send_item(OP_QUERY,  32'd20,  48'd0);
      send_item(OP_QUERY,  32'd20 + LATE_TOL_RESET, 48'd0);
      send_item(OP_QUERY,  32'd21 + LATE_TOL_RESET, 48'd0);
      send_item(OP_CLEAR,  32'd0,   48'd0);
      send_item(OP_QUERY,  32'd10,  48'd0);
      send_item(OP_APPEND, 32'd0,         48'h5555_5555_5555);
      send_item(OP_APPEND, 32'h8000_0000, 48'h0000_0000_0001);
      send_item(OP_APPEND, 32'hFFFF_FFFF, 48'h8000_0000_0000);
      send_item(OP_QUERY,  32'd0,         48'd0);
      send_item(OP_QUERY,  32'h7FFF_FFFF, 48'd0);
      send_item(OP_QUERY,  32'h8000_0000, 48'd0);
      send_item(OP_QUERY,  32'hFFFF_FFFF, 48'd0);
   endtask

   // Walk the tolerance through its extremes and probe both sides of its edge.
   task automatic test_late_tolerance();
      logic [31:0] tol_set [5];
      logic [31:0] t0;
      logic [31:0] t1;
      int          k;
      tol_set = '{32'd0, 32'd1, 32'hFFFF_FFFF, $urandom_range(2, 100000), LATE_TOL_RESET};
      for (k = 0; k < 5; k++) begin
         wait_idle();
         write_late_tolerance(tol_set[k]);
         t0 = (k % 2 == 0) ? $urandom_range(0, 100000) : pick_base_time();
         t1 = sat_add(t0, 7);
         send_item(OP_CLEAR,  32'd0, 48'd0);
         send_item(OP_APPEND, t0, rand_offset());
         send_item(OP_APPEND, t1, rand_offset());
         send_item(OP_APPEND, t1, rand_offset());
         send_item(OP_QUERY,  sat_add(t1, tol_model), 48'd0);
         send_item(OP_QUERY,  sat_add(sat_add(t1, tol_model), 1), 48'd0);
         send_item(OP_QUERY,  sat_add(t1, 1), 48'd0);
         send_item(OP_QUERY,  32'hFFFF_FFFF, 48'd0);
         send_item(OP_QUERY,  sat_add(t0, 3), 48'd0);
      end
   endtask

   // Fill the whole table, search it at full depth, and hit the full condition.
   task automatic test_table_full();
      logic [31:0] t;
      int          k;
      wait_idle();
      send_item(OP_CLEAR, 32'd0, 48'd0);
      t = $urandom_range(0, 1000);
      steady_mode = 1'b1;                    // first half back to back on both sides
      for (k = 0; k < TABLE_DEPTH; k++) begin
         if (k == TABLE_DEPTH / 2) steady_mode = 1'b0;
         t = next_time(t);
         send_item(OP_APPEND, t, rand_offset());
         if (k % 97 == 0) send_item(OP_QUERY, pick_query_time(), rand_offset());
      end
      send_item(OP_APPEND, sat_add(t, 1), rand_offset());
      send_item(OP_APPEND, t,             48'hFFFF_FFFF_FFFF);
      send_item(OP_APPEND, 32'd0,         48'd0);
      for (k = 0; k < 12; k++) send_item(OP_QUERY, pick_query_time(), 48'd0);
      send_item(OP_CLEAR, 32'd0, 48'd0);
      send_item(OP_QUERY, t,     48'd0);
   endtask

   // Sessions of clear, a sorted run of appends and targeted queries, salted with
   // out-of-order appends and random requests of any opcode.
   task automatic test_random_sessions(input int target);
      logic [31:0] t;
      logic [31:0] bad;
      int          start;
      int          sessions;
      int          n_append;
      int          k;
      int          roll;
      start    = n_items;
      sessions = 0;
      while (n_items - start < target) begin
         if (sessions % 6 == 5) begin
            wait_idle();
            write_late_tolerance(pick_tolerance());
         end
         steady_mode = ($urandom_range(0, 9) == 0);
         if (idx_count > 600 || $urandom_range(0, 3) != 0)
            send_item(OP_CLEAR, $urandom, rand_offset());
         roll = $urandom_range(0, 19);
         if (roll < 3) n_append = $urandom_range(0, 1);
         else if (roll < 17) n_append = $urandom_range(2, 24);
         else n_append = $urandom_range(25, 120);
         t = pick_base_time();
         for (k = 0; k < n_append; k++) begin
            if (idx_count > 0 && idx_time[idx_count-1] != 0 && $urandom_range(0, 11) == 0) begin
               bad = $urandom_range(0, 1) ? idx_time[idx_count-1] - 1
                                          : idx_time[idx_count-1] >> $urandom_range(1, 4);
               send_item(OP_APPEND, bad, rand_offset());
            end
            send_item(OP_APPEND, t, rand_offset());
            t = next_time(t);
         end
         for (k = $urandom_range(3, 12); k > 0; k--)
            send_item(OP_QUERY, pick_query_time(), rand_offset());
         if ($urandom_range(0, 3) == 0)
            send_item(logic'($urandom_range(0, 3)) ? OP_NOP : OP_NOP, $urandom, rand_offset());
         if ($urandom_range(0, 3) == 0)
            send_item(OP_W'($urandom_range(0, 3)), $urandom, rand_offset());
         sessions++;
      end
      steady_mode = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_single();
      test_floor_directed();
      test_late_tolerance();
      test_table_full();
      test_random_sessions(RANDOM_ITEMS);
      wait_idle();
      $display("Covered %0d requests and %0d no-ops: %0d queries (%0d matched),",
               n_items, n_nop, n_queries, n_matched);
      $display("%0d full rejects, %0d responses checked across %0d tolerance settings.",
               n_full, n_checked, n_tol_writes + 1);
      if (err_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ sorted_time_index_floor_lookup.f @@
hdl/tidx_pkg.sv
hdl/tidx_engine.sv
hdl/sorted_time_index_floor_lookup.sv
dv/tb_top.sv
